// ===== rtl/cfq_pkg.sv =====
// Package: operation codes, sequencer states and field widths for the scan queue.
`timescale 1ns / 1ps
`default_nettype none
package cfq_pkg;

	localparam int KIND_W  = 4;
	localparam int VALUE_W = 32;
	localparam int TOTAL_W = 42;
	localparam int CNT_W   = 10;

	typedef enum logic [3:0] {
		OP_ENQ    = 4'd0,
		OP_DEQ    = 4'd1,
		OP_PEEK   = 4'd2,
		OP_CLEAR  = 4'd3,
		OP_LOCATE = 4'd4,
		OP_COUNT  = 4'd5,
		OP_MAX    = 4'd6,
		OP_SUM    = 4'd7,
		OP_REMOVE = 4'd8,
		OP_REV    = 4'd9
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_WAIT,
		ST_EXEC,
		ST_WR2,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

// ===== rtl/cfq_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module cfq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== rtl/circular_fifo_queue_with_scans_top.sv =====
// Top level: ring-buffer queue with a sequenced scan unit over one RAM.
//
//  channel | dir | handshake            | payload
//  s_axis  | in  | s_axis_tvalid/tready | tuser: kind[3:0]; tdata: value[31:0]
//  m_axis  | out | m_axis_tvalid/tready | tdata: status, data_out, total, position,
//          |     |                      |        match_count, fill_level, is_empty, is_full
//
// The result follows the execute and done states for enqueue, clear, unknown codes and
// operations on an empty queue; dequeue and peek pass through read, wait, execute and done.
// Locate, count, max, sum and remove repeat read, wait and execute for each entry visited,
// as the single RAM read port is registered; reverse does two reads and two writes per pair.
// s_axis_tready stays low from the input transfer until the result transfer, so no new
// input is taken while an operation or its result is pending.
// Reset clears head, tail and the sequencer; RAM contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module circular_fifo_queue_with_scans_top
	import cfq_pkg::*;
#(
	parameter int DEPTH     = 1024,
	parameter int WORD_BITS = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_axis_tvalid,
	output logic                     s_axis_tready,
	// value[31:0]
	input  wire logic [VALUE_W-1:0]  s_axis_tdata,
	// kind[3:0]
	input  wire logic [KIND_W-1:0]   s_axis_tuser,
	output logic                     m_axis_tvalid,
	input  wire logic                m_axis_tready,
	// status[0], data_out[32:1], total[74:33], position[84:75],
	// match_count[94:85], fill_level[104:95], is_empty[105], is_full[106], zero fill
	output logic [111:0]             m_axis_tdata
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [AW-1:0] LASTI = AW'(DEPTH - 1);

	// index helpers, wrap modulo DEPTH
	function automatic logic [AW-1:0] inc(input logic [AW-1:0] i);
		return (i == LASTI) ? '0 : i + 1'b1;
	endfunction
	function automatic logic [AW-1:0] dec(input logic [AW-1:0] i);
		return (i == '0) ? LASTI : i - 1'b1;
	endfunction

	state_t state_q, state_d;
	logic [AW-1:0] head_q, tail_q, ri_q, wi_q, lp_q, rp_q;
	logic [AW:0]   k_q, half_q;
	logic [CNT_W-1:0] pos_q, cnt_q;
	logic [TOTAL_W-1:0] sum_q;
	logic [WORD_BITS-1:0] best_q, key_q, tmp_q;
	logic found_q, stat_q, first_q, ph_q;
	op_t op_q;

	logic we;
	logic [AW-1:0] waddr, raddr;
	logic [WORD_BITS-1:0] wdata, rdata;

	logic in_stat, in_rd, hit, scan_go, scan_more;

	cfq_ram #(.WIDTH(WORD_BITS), .DEPTH(DEPTH)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	logic [AW-1:0] lvl;
	assign lvl = (tail_q >= head_q) ? tail_q - head_q : AW'(tail_q + AW'(DEPTH) - head_q);

	logic m_valid_q;
	assign m_axis_tvalid = m_valid_q;
	assign s_axis_tready = (state_q == ST_IDLE) && !m_valid_q;

	logic acc;
	assign acc = s_axis_tvalid && s_axis_tready;

	// scan step decisions
	assign hit       = (rdata == key_q);
	assign scan_go   = (lvl != '0) && !stat_q;
	assign scan_more = (inc(ri_q) != tail_q) && !(op_q == OP_LOCATE && (found_q || hit));

	// status and first step of an incoming operation
	always_comb begin
		in_stat = 1'b0;
		in_rd   = 1'b0;
		case (s_axis_tuser)
			OP_ENQ: in_stat = (inc(tail_q) == head_q);
			OP_DEQ, OP_PEEK, OP_MAX: begin
				in_stat = (lvl == '0);
				in_rd   = (lvl != '0);
			end
			OP_CLEAR: ;
			OP_LOCATE, OP_COUNT, OP_SUM, OP_REMOVE: in_rd = (lvl != '0);
			OP_REV: in_rd = ((lvl >> 1) != '0);
			default: in_stat = 1'b1;
		endcase
	end

	// read address: scan pointer, or swap partner on reverse second phase
	always_comb begin
		raddr = (op_q == OP_REV && ph_q) ? rp_q : ri_q;
	end

	// signed word to total width
	logic [TOTAL_W-1:0] rd_ext;
	assign rd_ext = TOTAL_W'($signed(rdata));

	// write port
	always_comb begin
		we = 1'b0;
		waddr = tail_q;
		wdata = key_q;
		if (state_q == ST_EXEC && op_q == OP_ENQ && !stat_q) begin
			we = 1'b1;
		end else if (state_q == ST_EXEC && op_q == OP_REMOVE && !hit) begin
			we = 1'b1;
			waddr = wi_q;
			wdata = rdata;
		end else if (state_q == ST_EXEC && op_q == OP_REV && ph_q) begin
			we = 1'b1;
			waddr = lp_q;
			wdata = rdata;
		end else if (state_q == ST_WR2) begin
			we = 1'b1;
			waddr = rp_q;
			wdata = tmp_q;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (acc) state_d = in_rd ? ST_RD : ST_EXEC;
			ST_RD:   state_d = ST_WAIT;
			ST_WAIT: state_d = ST_EXEC;
			ST_EXEC: begin
				state_d = ST_DONE;
				case (op_q)
					OP_LOCATE, OP_COUNT, OP_MAX, OP_SUM, OP_REMOVE:
						if (scan_go && scan_more) state_d = ST_RD;
					OP_REV:
						if (half_q != '0) state_d = ph_q ? ST_WR2 : ST_RD;
					default: ;
				endcase
			end
			ST_WR2:  state_d = (k_q + 1'b1 < half_q) ? ST_RD : ST_DONE;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// queue pointers, scan registers and result flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			tail_q    <= '0;
			m_valid_q <= 1'b0;
			ri_q <= '0; wi_q <= '0; lp_q <= '0; rp_q <= '0;
			k_q <= '0; half_q <= '0; ph_q <= 1'b0; found_q <= 1'b0;
			first_q <= 1'b0; stat_q <= 1'b0; op_q <= OP_ENQ;
			pos_q <= '0; cnt_q <= '0; sum_q <= '0;
			best_q <= '0; key_q <= '0; tmp_q <= '0;
		end else begin
			if (state_q == ST_DONE) m_valid_q <= 1'b1;
			else if (m_axis_tready) m_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						op_q    <= op_t'(s_axis_tuser);
						key_q   <= WORD_BITS'(s_axis_tdata);
						stat_q  <= in_stat;
						pos_q   <= '0;
						cnt_q   <= '0;
						sum_q   <= '0;
						best_q  <= '0;
						found_q <= 1'b0;
						first_q <= 1'b1;
						ph_q    <= 1'b0;
						ri_q    <= head_q;
						wi_q    <= head_q;
						lp_q    <= head_q;
						rp_q    <= dec(tail_q);
						k_q     <= '0;
						half_q  <= (AW+1)'(lvl >> 1);
					end
				end
				ST_EXEC: begin
					case (op_q)
						OP_ENQ: if (!stat_q) tail_q <= inc(tail_q);
						OP_DEQ, OP_PEEK: begin
							if (!stat_q) begin
								best_q <= rdata;
								if (op_q == OP_DEQ) head_q <= inc(head_q);
							end
						end
						OP_CLEAR: begin
							head_q <= '0;
							tail_q <= '0;
						end
						OP_LOCATE, OP_COUNT, OP_MAX, OP_SUM, OP_REMOVE: begin
							if (scan_go) begin
								k_q <= k_q + 1'b1;
								if (hit && !found_q) begin
									found_q <= 1'b1;
									pos_q   <= CNT_W'(k_q + 1'b1);
								end
								if (hit) cnt_q <= cnt_q + 1'b1;
								sum_q <= sum_q + rd_ext;
								if (first_q || $signed(rdata) > $signed(best_q)) best_q <= rdata;
								first_q <= 1'b0;
								if (op_q == OP_REMOVE && !hit) wi_q <= inc(wi_q);
								if (scan_more) begin
									ri_q <= inc(ri_q);
								end else if (op_q == OP_REMOVE) begin
									tail_q <= hit ? wi_q : inc(wi_q);
								end
							end
						end
						OP_REV: begin
							if (half_q != '0 && !ph_q) begin
								tmp_q <= rdata;
								ph_q  <= 1'b1;
							end
						end
						default: ;
					endcase
				end
				ST_WR2: begin
					ph_q <= 1'b0;
					lp_q <= inc(lp_q);
					ri_q <= inc(lp_q);
					rp_q <= dec(rp_q);
					k_q  <= k_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	// result word
	logic [31:0] data_f;
	logic [TOTAL_W-1:0] tot_f;
	always_comb begin
		data_f = '0;
		tot_f  = '0;
		if ((op_q == OP_DEQ || op_q == OP_PEEK || op_q == OP_MAX) && !stat_q)
			data_f = 32'($signed(best_q));
		if (op_q == OP_SUM) tot_f = sum_q;
	end

	assign m_axis_tdata = {5'd0,
		(lvl == LASTI),
		(lvl == '0),
		CNT_W'(lvl),
		(op_q == OP_COUNT) ? cnt_q : CNT_W'(0),
		(op_q == OP_LOCATE) ? pos_q : CNT_W'(0),
		tot_f,
		data_f,
		stat_q};

endmodule
`default_nettype wire
